>>> design/ohrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohrb_pkg
// Shared constants for the overwriting history ring buffer and its checker.
// ----------------------------------------------------------------------------
package ohrb_pkg;

  // Width of counts, the capacity register and the request count
  localparam int CNT_W = 6;

  // Built defaults
  localparam int DEPTH_DEF      = 32;
  localparam int WORD_WIDTH_DEF = 32;

  // Capacity after reset, before clamping to the built depth
  localparam int CAP_RESET = 32;

  // Width of an input action and of a result value
  localparam int ACT_W   = 2;
  localparam int VALUE_W = 32;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_STORE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DUMP  = 2'd2;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

endpackage

>>> design/overwriting_history_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_history_ring_buffer
// Ring buffer of the most recent words, overwriting the oldest when full,
// with a dump that streams out a count header and then the newest words.
// ----------------------------------------------------------------------------
// A store or a clear needs no result, so they can be transferred back to
// back in every cycle outside a dump, even while a result waits on a
// stalled output. A dump of n words gives n + 1 result transfers: the count
// header in the cycle after the dump is taken, then one word per cycle
// while the output does not stall, out of the slot memory's single
// registered read port. While the words of a dump stream out the
// input is stalled; a dump also waits while a previous result sits stalled
// on the output. Writing the capacity register (clamped to 1..DEPTH) empties
// the buffer. The slot memory needs no clearing after reset: only slots that
// have been written since the last clear are ever read.
// ----------------------------------------------------------------------------
module overwriting_history_ring_buffer #(
  parameter int DEPTH      = ohrb_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = ohrb_pkg::WORD_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write
  input  logic                        cfg_we_i,
  input  logic [ohrb_pkg::CNT_W-1:0]  cfg_wdata_i,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ohrb_pkg::ACT_W-1:0]  action_i,
  input  logic [31:0]                 data_word_i,
  input  logic [ohrb_pkg::CNT_W-1:0]  request_count_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [ohrb_pkg::VALUE_W-1:0] value_o,
  output logic                        last_o
);

  import ohrb_pkg::*;

  // Slot index width; a single-slot build still keeps one address bit
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_RST_C = (CAP_RESET < DEPTH) ? CNT_W'(CAP_RESET)
                                                               : CNT_W'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  // Control and output registers
  state_e             state_q,     state_d;
  logic [CNT_W-1:0]   cap_q,       cap_d;
  logic [IDX_W-1:0]   oldest_q,    oldest_d;
  logic [CNT_W-1:0]   count_q,     count_d;
  logic [IDX_W-1:0]   rd_ptr_q,    rd_ptr_d;
  logic [CNT_W-1:0]   remain_q,    remain_d;
  logic               out_valid_q, out_valid_d;
  logic               kind_q,      kind_d;
  logic               last_q,      last_d;
  logic [CNT_W-1:0]   header_q,    header_d;

  // Slot memory and its registered read data
  logic [WORD_WIDTH-1:0] mem_q [DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_q;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_WIDTH-1:0] wr_word;
  logic [63:0]           din_ext;
  logic [63:0]           rd_ext;
  logic                  rd_en;

  logic                  in_xfer;
  logic                  out_free;
  logic                  full;
  logic [CNT_W-1:0]      dump_n;
  logic [CNT_W-1:0]      first_off;
  logic [CNT_W-1:0]      cfg_cap;

  // Slot that lies off slots past base, wrapping at the capacity
  function automatic logic [IDX_W-1:0] slot_wrap(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] sum;
    sum = {1'b0, CNT_W'(base)} + {1'b0, off};
    if (sum >= {1'b0, cap}) begin
      sum = sum - {1'b0, cap};
    end
    return IDX_W'(sum);
  endfunction

  // Handshakes: a dump needs the output register, store and clear do not
  assign in_stall_o = (state_q == ST_DUMP) ||
                      ((action_i == ACT_DUMP) && out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign full      = (count_q >= cap_q);
  assign dump_n    = (count_q < request_count_i) ? count_q : request_count_i;
  assign first_off = count_q - dump_n;

  // Clamp a written capacity to 1..DEPTH
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_cap = CNT_W'(1);
    end else if (cfg_wdata_i > DEPTH_C) begin
      cfg_cap = DEPTH_C;
    end else begin
      cfg_cap = cfg_wdata_i;
    end
  end

  // Fit the incoming word to the stored width
  assign din_ext = 64'(data_word_i);
  assign wr_word = din_ext[WORD_WIDTH-1:0];

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    remain_d    = remain_q;
    kind_d      = kind_q;
    last_d      = last_q;
    header_d    = header_q;
    // Drop the result once it has been transferred
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = oldest_q;
    rd_en       = 1'b0;

    if (cfg_we_i) begin
      // New capacity: empty the buffer
      cap_d    = cfg_cap;
      oldest_d = '0;
      count_d  = '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (action_i)
              ACT_STORE: begin
                wr_en = 1'b1;
                if (!full) begin
                  wr_addr = slot_wrap(oldest_q, count_q, cap_q);
                  count_d = count_q + CNT_W'(1);
                end else begin
                  // Full: overwrite the oldest word and advance past it
                  wr_addr  = oldest_q;
                  oldest_d = slot_wrap(oldest_q, CNT_W'(1), cap_q);
                end
              end
              ACT_CLEAR: begin
                oldest_d = '0;
                count_d  = '0;
              end
              ACT_DUMP: begin
                header_d    = dump_n;
                kind_d      = KIND_HEADER;
                last_d      = (dump_n == '0);
                out_valid_d = 1'b1;
                if (dump_n != '0) begin
                  state_d  = ST_DUMP;
                  rd_ptr_d = slot_wrap(oldest_q, first_off, cap_q);
                  remain_d = dump_n;
                end
              end
              default: begin
                // Unused code: no result, state unchanged
              end
            endcase
          end
        end
        ST_DUMP: begin
          // Read the next word only when the output register will be free
          if (out_free) begin
            rd_en       = 1'b1;
            rd_ptr_d    = slot_wrap(rd_ptr_q, CNT_W'(1), cap_q);
            remain_d    = remain_q - CNT_W'(1);
            kind_d      = KIND_WORD;
            last_d      = (remain_q == CNT_W'(1));
            out_valid_d = 1'b1;
            if (remain_q == CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RST_C;
      oldest_q    <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_HEADER;
      last_q      <= 1'b0;
      header_q    <= '0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      last_q      <= last_d;
      header_q    <= header_d;
    end
  end

  // Slot memory: one write port, one read port with registered data.
  // The read data holds while the output is stalled, as no read is issued.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign rd_ext = 64'(rd_data_q);

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;
  assign value_o     = (kind_q == KIND_WORD) ? rd_ext[VALUE_W-1:0] : VALUE_W'(header_q);

endmodule

>>> design/ohrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohrb_port_checks
// Port-level checks on the result stream of the history ring buffer.
// ----------------------------------------------------------------------------
module ohrb_port_checks #(
  parameter int DEPTH = ohrb_pkg::DEPTH_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [ohrb_pkg::ACT_W-1:0]   action_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         kind_o,
  input logic [ohrb_pkg::VALUE_W-1:0] value_o,
  input logic                         last_o
);

  import ohrb_pkg::*;

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(kind_o) && $stable(value_o) && $stable(last_o))
    else $error("stalled result changed");

  // A header marked last announces no words
  a_empty_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_HEADER) && last_o |-> value_o == '0)
    else $error("last header with nonzero count");

  // A header with words to follow is never last, and never exceeds the depth
  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_HEADER) && (value_o != '0) |->
      !last_o && (value_o <= VALUE_W'(DEPTH)))
    else $error("bad header count or last flag");

  // While a data word that is not last is transferred, the input is stalled
  a_dump_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (kind_o == KIND_WORD) && !last_o |-> in_stall_o)
    else $error("input taken in the middle of a dump");

  // Hold off a dump while a result sits stalled on the output
  a_dump_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && (action_i == ACT_DUMP) && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("dump taken while a result was stalled");

endmodule

bind overwriting_history_ring_buffer ohrb_port_checks #(.DEPTH(DEPTH)) u_ohrb_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .value_o     (value_o),
  .last_o      (last_o)
);
